// ===== rtl/core/fvbb_pkg.sv =====
package fvbb_pkg;

  // Filter and channel configuration.
  localparam int FILTER_LEN   = 10;
  localparam int NUM_CHANNELS = 2;

  // Field widths.
  localparam int PRESS_W = 16;
  localparam int LIMIT_W = 15;
  localparam int FSUM_W  = 20;

  // The channel field is one bit wide, so at most two channels are ever addressed.
  localparam int CH_SLOTS = 2;
  localparam int NCH      = (NUM_CHANNELS < CH_SLOTS) ? NUM_CHANNELS : CH_SLOTS;

  localparam int HIST_DEPTH = NCH * FILTER_LEN;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SLOT_W     = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;

  // Exact running sum, never narrower than the reported field.
  localparam int SUM_EXACT_W = PRESS_W + $clog2(FILTER_LEN);
  localparam int SUM_W       = (SUM_EXACT_W > FSUM_W) ? SUM_EXACT_W : FSUM_W;
  // Thresholds are FILTER_LEN times an 18 bit signed value.
  localparam int THR_W       = SUM_W + 2;

  localparam logic signed [THR_W-1:0] FILTER_LEN_S = THR_W'(FILTER_LEN);
  localparam logic [HIST_AW-1:0]      CH1_BASE     = HIST_AW'(FILTER_LEN);
  localparam logic [SLOT_W-1:0]       SLOT_LAST    = SLOT_W'(FILTER_LEN - 1);

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_SETPOINT_CH0 = 3'd0;
  localparam logic [2:0] REG_SETPOINT_CH1 = 3'd1;
  localparam logic [2:0] REG_DEADBAND     = 3'd2;
  localparam logic [2:0] REG_UNDERSHOOT   = 3'd3;
  localparam logic [2:0] REG_NOISE_FLOOR  = 3'd4;

  localparam logic signed [PRESS_W-1:0] SETPOINT_CH0_RST = 16'sd256;
  localparam logic signed [PRESS_W-1:0] SETPOINT_CH1_RST = -16'sd256;

endpackage

// ===== rtl/core/filtered_valve_bang_bang_control.sv =====
// Moving-average bang-bang valve controller with a deadband.
//
// Input request: channel_i and pressure_i under in_valid_i / in_stall_o. Each
// accepted sample replaces the oldest of its channel's FILTER_LEN samples and
// produces exactly one valve command on the output request: out_channel_o,
// vent_open_o, inflate_open_o and filtered_sum_o under out_valid_o / out_stall_i.
// A sample on a channel that is not present leaves the state alone and yields
// a sealed command with a zero sum.
// After its sample is accepted, a command passes through the RAM stage and then
// into the output register. One sample can be accepted every cycle while
// in_stall_o is low. The history RAM is read and written at the same address in
// the accept cycle, and the per-channel sums are updated in the following stage,
// so back-to-back samples of one channel need no stall. When the receiver stalls,
// the command holds in the output register, one more sample waits in the RAM
// stage, and in_stall_o rises only when both are full. Reset clears the histories
// through per-entry valid bits, zeroes the sums and write slots, and loads the
// registers with their reset values. The registers are written over the APB port;
// the user must change them only while the block is idle, which the block itself
// does not enforce.
module filtered_valve_bang_bang_control
  import fvbb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // Sample request
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       channel_i,
  input  logic signed [PRESS_W-1:0]  pressure_i,
  // Command request
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_channel_o,
  output logic                       vent_open_o,
  output logic                       inflate_open_o,
  output logic signed [FSUM_W-1:0]   filtered_sum_o
);

  // Configuration registers
  logic signed [PRESS_W-1:0] setpoint_q [CH_SLOTS];
  logic [LIMIT_W-1:0]        deadband_q;
  logic [LIMIT_W-1:0]        undershoot_q;
  logic [LIMIT_W-1:0]        noise_floor_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  // Per-channel decision limits derived from the configuration
  logic signed [THR_W-1:0]   thr_hi_q [CH_SLOTS];
  logic signed [THR_W-1:0]   thr_lo_q [CH_SLOTS];
  logic                      seal_q [CH_SLOTS];
  logic                      force_vent_q [CH_SLOTS];

  // Per-channel state kept in flops
  logic signed [SUM_W-1:0]   sum_q [CH_SLOTS];
  logic [SLOT_W-1:0]         slot_q [CH_SLOTS];
  logic [HIST_DEPTH-1:0]     hist_vld_q;

  // Accept stage
  logic                      advance;
  logic                      out_take;
  logic                      accept;
  logic                      in_present;
  logic [SLOT_W-1:0]         cur_slot;
  logic [HIST_AW-1:0]        hist_addr;
  logic [PRESS_W-1:0]        hist_rdata;

  // RAM stage
  logic                      s1_valid_q;
  logic                      s1_ch_q;
  logic                      s1_present_q;
  logic                      s1_hvld_q;
  logic signed [PRESS_W-1:0] s1_press_q;
  logic signed [PRESS_W-1:0] old_sample;
  logic signed [SUM_W-1:0]   sum_new;
  logic signed [THR_W-1:0]   sum_ext;
  logic                      vent_d;
  logic                      infl_d;

  // Output register
  logic                      out_valid_q;
  logic                      out_ch_q;
  logic                      vent_q;
  logic                      infl_q;
  logic signed [FSUM_W-1:0]  fsum_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q[0] <= SETPOINT_CH0_RST;
      setpoint_q[1] <= SETPOINT_CH1_RST;
      deadband_q    <= '0;
      undershoot_q  <= '0;
      noise_floor_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SETPOINT_CH0: setpoint_q[0] <= pwdata[PRESS_W-1:0];
        REG_SETPOINT_CH1: setpoint_q[1] <= pwdata[PRESS_W-1:0];
        REG_DEADBAND:     deadband_q    <= pwdata[LIMIT_W-1:0];
        REG_UNDERSHOOT:   undershoot_q  <= pwdata[LIMIT_W-1:0];
        REG_NOISE_FLOOR:  noise_floor_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SETPOINT_CH0: prdata = PDATA_W'(setpoint_q[0]);
      REG_SETPOINT_CH1: prdata = PDATA_W'(setpoint_q[1]);
      REG_DEADBAND:     prdata = PDATA_W'(deadband_q);
      REG_UNDERSHOOT:   prdata = PDATA_W'(undershoot_q);
      REG_NOISE_FLOOR:  prdata = PDATA_W'(noise_floor_q);
      default:          prdata = '0;
    endcase
  end

  // The limits follow the registers in the next cycle, so they are in place when
  // any sample accepted after a write reaches the decision.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CH_SLOTS; c++) begin
      thr_hi_q[c] <= (THR_W'(setpoint_q[c]) + $signed(THR_W'(deadband_q))) * FILTER_LEN_S;
      thr_lo_q[c] <= (THR_W'(setpoint_q[c]) - $signed(THR_W'(undershoot_q))) * FILTER_LEN_S;
      seal_q[c]   <= setpoint_q[c][PRESS_W-1];
      force_vent_q[c] <= $signed(THR_W'(setpoint_q[c])) <= $signed(THR_W'(noise_floor_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign out_take   = ~out_valid_q | ~out_stall_i;
  assign advance    = ~s1_valid_q | out_take;
  assign accept     = in_valid_i & advance;
  assign in_stall_o = ~advance;

  // ---------------------------------------------------------------------------
  // Accept stage: read the oldest sample and write the new one in its place
  // ---------------------------------------------------------------------------
  assign in_present = (NCH > 1) ? 1'b1 : ~channel_i;
  assign cur_slot   = slot_q[channel_i];

  always_comb begin
    if (channel_i && (NCH > 1)) begin
      hist_addr = CH1_BASE + HIST_AW'(cur_slot);
    end else begin
      hist_addr = HIST_AW'(cur_slot);
    end
  end

  fvbb_ram #(
    .WIDTH (PRESS_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (accept & in_present),
    .waddr_i (hist_addr),
    .wdata_i (pressure_i),
    .re_i    (accept),
    .raddr_i (hist_addr),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      for (int c = 0; c < CH_SLOTS; c++) begin
        slot_q[c] <= '0;
      end
    end else if (accept && in_present) begin
      hist_vld_q[hist_addr] <= 1'b1;
      slot_q[channel_i]     <= (cur_slot == SLOT_LAST) ? '0 : cur_slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q      <= channel_i;
      s1_present_q <= in_present;
      s1_hvld_q    <= hist_vld_q[hist_addr];
      s1_press_q   <= pressure_i;
    end
  end

  // ---------------------------------------------------------------------------
  // RAM stage: update the running sum and decide the valve command
  // ---------------------------------------------------------------------------
  assign old_sample = s1_hvld_q ? hist_rdata : '0;
  assign sum_new    = sum_q[s1_ch_q] + SUM_W'(s1_press_q) - SUM_W'(old_sample);
  assign sum_ext    = THR_W'(sum_new);

  always_comb begin
    vent_d = 1'b0;
    infl_d = 1'b0;
    if (!s1_present_q || seal_q[s1_ch_q]) begin
      vent_d = 1'b0;
    end else if (force_vent_q[s1_ch_q]) begin
      vent_d = 1'b1;
    end else if (sum_ext > thr_hi_q[s1_ch_q]) begin
      vent_d = 1'b1;
    end else if (sum_ext < thr_lo_q[s1_ch_q]) begin
      infl_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CH_SLOTS; c++) begin
        sum_q[c] <= '0;
      end
    end else if (s1_valid_q && out_take && s1_present_q) begin
      sum_q[s1_ch_q] <= sum_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_take) begin
      out_ch_q <= s1_ch_q;
      vent_q   <= vent_d;
      infl_q   <= infl_d;
      fsum_q   <= s1_present_q ? sum_new[FSUM_W-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign vent_open_o    = vent_q;
  assign inflate_open_o = infl_q;
  assign filtered_sum_o = fsum_q;

endmodule

// ===== rtl/core/fvbb_ram.sv =====
module fvbb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
